### rtl/core/rlc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlc_pkg: shared types and constants for the radius leader clustering block
// Holds the default sizes, register indexes and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package rlc_pkg;
  localparam int MaxClustersDef = 32;
  localparam int CoordWidthDef  = 24;
  localparam int CountWidthDef  = 16;
  localparam int NComp          = 7;
  localparam int RadiusWidth    = 48;
  localparam int ThreshWidth    = 16;
  localparam int IndexWidth     = 5;

  localparam logic [RadiusWidth-1:0] RadiusReset = 48'd1073741824;
  localparam logic [ThreshWidth-1:0] ThreshReset = 16'd10;

  localparam logic CfgRadius = 1'b0;
  localparam logic CfgThresh = 1'b1;

  localparam logic ActAdd   = 1'b0;
  localparam logic ActClear = 1'b1;

  typedef struct packed {
    logic load;       // capture the request
    logic scan_rd;    // issue read of scan entry
    logic dist_calc;  // square differences
    logic dist_sum;   // add squares and compare
    logic upd_rd;     // read sums of hit entry
    logic div_start;  // launch divisions
    logic comp_next;  // advance component
    logic write_new;  // write a fresh cluster
    logic write_upd;  // write back the current component
    logic cnt_write;  // write the new count
  } rlc_cmd_t;

  typedef struct packed {
    logic hit;
    logic div_done;
    logic sat;
  } rlc_sts_t;
endpackage
`default_nettype wire

### rtl/core/rlc_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlc_divider: signed restoring divider
// Divides a signed sum by an unsigned count one quotient bit per cycle and
// truncates toward zero.
// ----------------------------------------------------------------------------
module rlc_divider #(
  parameter int NumWidth = 40,
  parameter int DenWidth = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic signed [NumWidth-1:0] num,
  input  wire logic [DenWidth-1:0]        den,
  output logic                            done,
  output logic signed [NumWidth-1:0]      quot
);
  localparam int StepW = $clog2(NumWidth + 1);

  logic [NumWidth-1:0] mag;
  logic [DenWidth:0]   rem;
  logic [DenWidth-1:0] dv;
  logic                neg;
  logic [StepW-1:0]    steps;
  logic                busy;
  logic [DenWidth:0]   trial;
  logic [DenWidth:0]   shifted;

  always_comb begin
    shifted = {rem[DenWidth-1:0], mag[NumWidth-1]};
    trial   = shifted - {1'b0, dv};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= StepW'(NumWidth);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == StepW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= num[NumWidth-1];
      mag <= num[NumWidth-1] ? NumWidth'(-num) : NumWidth'(num);
      rem <= '0;
      dv  <= den;
    end else if (busy) begin
      if (!trial[DenWidth]) begin
        rem <= trial;
        mag <= {mag[NumWidth-2:0], 1'b1};
      end else begin
        rem <= shifted;
        mag <= {mag[NumWidth-2:0], 1'b0};
      end
    end
  end

  assign quot = neg ? -$signed(mag) : $signed(mag);
endmodule
`default_nettype wire

### rtl/core/rlc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlc_datapath: cluster storage, distance unit and centroid update
// Holds the centroid, sum and count memories, computes squared distances
// one cluster at a time and recomputes centroids one component at a time.
// ----------------------------------------------------------------------------
module rlc_datapath import rlc_pkg::*; #(
  parameter int MaxClusters = MaxClustersDef,
  parameter int CoordWidth  = CoordWidthDef,
  parameter int CountWidth  = CountWidthDef
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire rlc_cmd_t                      cmd,
  output rlc_sts_t                           sts,
  input  wire logic [$clog2(MaxClusters)-1:0] scan_idx,
  input  wire logic [$clog2(NComp)-1:0]      comp,
  input  wire logic [RadiusWidth-1:0]        radius_squared,
  input  wire logic [NComp*CoordWidth-1:0]   det_in,
  output logic [CountWidth-1:0]              count_out,
  output logic [NComp*CoordWidth-1:0]        mean_out
);
  localparam int Iw  = $clog2(MaxClusters);
  localparam int Cw  = $clog2(NComp);
  localparam int Sw  = CoordWidth + CountWidth;
  localparam int Dw  = CoordWidth + 1;
  localparam int Qw  = 2 * Dw;
  localparam int Aw  = Qw + 2;
  localparam int Mw  = $clog2(MaxClusters * NComp);
  localparam int Depth = MaxClusters * NComp;

  logic [CoordWidth-1:0] cent_mem [Depth];
  logic [Sw-1:0]         sum_mem  [Depth];
  logic [CountWidth-1:0] cnt_mem  [MaxClusters];

  logic [NComp*CoordWidth-1:0] det;
  logic [CoordWidth-1:0] cent_rd [3];
  logic [CountWidth-1:0] cnt_rd;
  logic [Qw-1:0]         sq [3];
  logic [Sw-1:0]         sum_rd;
  logic [CountWidth-1:0] new_cnt;
  logic [Sw-1:0]         new_sum;
  logic                  div_done;
  logic signed [Sw-1:0]  quot;
  logic [Aw-1:0]         sq_total;
  logic                  hit;
  logic                  hit_r;

  function automatic logic [Mw-1:0] addr(input logic [Iw-1:0] i, input logic [Cw-1:0] c);
    logic [Mw+Cw:0] a;
    a = (Mw+Cw+1)'(i) * (Mw+Cw+1)'(NComp) + (Mw+Cw+1)'(c);
    return a[Mw-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load) det <= det_in;
  end

  // three centroid reads per scan step, from one copy per axis
  logic [CoordWidth-1:0] ax_mem [3][MaxClusters];
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (cmd.scan_rd) cent_rd[k] <= ax_mem[k][scan_idx];
    end
    if (cmd.scan_rd) cnt_rd <= cnt_mem[scan_idx];
    if (cmd.upd_rd || cmd.comp_next) sum_rd <= sum_mem[addr(scan_idx, comp)];
  end

  always_ff @(posedge clk) begin
    if (cmd.dist_calc) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [Dw-1:0] d;
        d = Dw'($signed(cent_rd[k])) - Dw'($signed(det[k*CoordWidth +: CoordWidth]));
        sq[k] <= Qw'(d) * Qw'(d);
      end
    end
  end

  assign sq_total = Aw'(sq[0]) + Aw'(sq[1]) + Aw'(sq[2]);
  assign hit      = (sq_total < Aw'(radius_squared));

  always_ff @(posedge clk) begin
    if (rst) hit_r <= 1'b0;
    else if (cmd.dist_sum) hit_r <= hit;
  end
  assign sts.hit = hit_r;
  assign sts.sat = &cnt_rd;
  assign new_cnt = cnt_rd + 1'b1;

  logic [CoordWidth-1:0] det_c;
  assign det_c   = det[comp*CoordWidth +: CoordWidth];
  assign new_sum = sum_rd + Sw'($signed(det_c));

  rlc_divider #(.NumWidth(Sw), .DenWidth(CountWidth)) u_div (
    .clk, .rst,
    .start(cmd.div_start),
    .num  ($signed(new_sum)),
    .den  (new_cnt),
    .done (div_done),
    .quot (quot)
  );
  assign sts.div_done = div_done;

  logic [Sw-1:0] sum_hold;
  always_ff @(posedge clk) begin
    if (cmd.div_start) sum_hold <= new_sum;
  end

  always_ff @(posedge clk) begin
    if (cmd.write_new) begin
      sum_mem[addr(scan_idx, comp)]  <= Sw'($signed(det_c));
      cent_mem[addr(scan_idx, comp)] <= det_c;
      if (comp < Cw'(3)) ax_mem[comp[1:0]][scan_idx] <= det_c;
    end else if (cmd.write_upd) begin
      sum_mem[addr(scan_idx, comp)]  <= sum_hold;
      cent_mem[addr(scan_idx, comp)] <= quot[CoordWidth-1:0];
      if (comp < Cw'(3)) ax_mem[comp[1:0]][scan_idx] <= quot[CoordWidth-1:0];
    end
    if (cmd.cnt_write) cnt_mem[scan_idx] <= cmd.write_new ? CountWidth'(1) : new_cnt;
  end

  // result gather: capture the centroid component by component, from the written value or a memory read
  always_ff @(posedge clk) begin
    if (cmd.write_new) begin
      mean_out[comp*CoordWidth +: CoordWidth] <= det_c;
      count_out <= CountWidth'(1);
    end else if (cmd.write_upd) begin
      mean_out[comp*CoordWidth +: CoordWidth] <= quot[CoordWidth-1:0];
      count_out <= new_cnt;
    end else if (cmd.comp_next && !cmd.div_start) begin
      mean_out[comp*CoordWidth +: CoordWidth] <= cent_mem[addr(scan_idx, comp)];
      count_out <= cnt_rd;
    end
  end
endmodule
`default_nettype wire

### rtl/core/rlc_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlc_controller: request sequencer
// Scans clusters, then opens, updates, reports a saturated one unchanged or
// drops, and hands the result to the output register.
// ----------------------------------------------------------------------------
module rlc_controller import rlc_pkg::*; #(
  parameter int MaxClusters = MaxClustersDef
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            action,
  output rlc_cmd_t                             cmd,
  input  wire rlc_sts_t                        sts,
  output logic [$clog2(MaxClusters)-1:0]       scan_idx,
  output logic [$clog2(NComp)-1:0]             comp,
  output logic                                 res_valid,
  input  wire logic                            res_ready,
  output logic [2:0]                           res_kind
);
  localparam int Iw = $clog2(MaxClusters);
  localparam int Tw = $clog2(MaxClusters + 1);
  localparam int Cw = $clog2(NComp);

  localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_SQ = 4'd2, S_CMP = 4'd3,
                         S_DEC = 4'd4, S_NEW = 4'd5, S_URD = 4'd6, S_DIV = 4'd7,
                         S_WB = 4'd8, S_GRD = 4'd9, S_OUT = 4'd10, S_GATH = 4'd11;
  // res_kind: [0] created [1] dropped [2] zero result
  logic [3:0]    state;
  logic [Tw-1:0] total;
  logic [Tw-1:0] pos;

  assign in_ready = (state == S_IDLE) && !res_valid;
  assign scan_idx = pos[Iw-1:0];

  always_comb begin
    cmd = '0;
    cmd.load = in_valid && in_ready;
    case (state)
      S_RD:   cmd.scan_rd = 1'b1;
      S_SQ:   cmd.dist_calc = 1'b1;
      S_CMP:  cmd.dist_sum = 1'b1;
      S_NEW:  begin cmd.write_new = 1'b1; cmd.cnt_write = (comp == '0); end
      S_URD:  cmd.upd_rd = 1'b1;
      S_DIV:  cmd.div_start = 1'b1;
      S_WB:   if (sts.div_done) begin
                cmd.write_upd = 1'b1;
                cmd.cnt_write = (comp == '0);
              end
      S_GRD:  cmd.comp_next = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      total     <= '0;
      res_valid <= 1'b0;
      res_kind  <= '0;
      pos       <= '0;
      comp      <= '0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid && in_ready) begin
          pos  <= '0;
          comp <= '0;
          if (action == ActClear) begin
            total     <= '0;
            res_kind  <= 3'b100;
            res_valid <= 1'b1;
          end else if (total == '0) begin
            state <= S_DEC;
          end else begin
            state <= S_RD;
          end
        end
        S_RD:  state <= S_SQ;
        S_SQ:  state <= S_CMP;
        S_CMP: state <= S_DEC;
        S_DEC: begin
          if (pos != total && sts.hit) begin
            state <= sts.sat ? S_GRD : S_URD;
          end else if (pos != total && pos + 1'b1 != total) begin
            pos   <= pos + 1'b1;
            state <= S_RD;
          end else begin
            if (pos != total) pos <= pos + 1'b1;
            if (total == Tw'(MaxClusters)) begin
              res_kind  <= 3'b110;
              res_valid <= 1'b1;
              state     <= S_IDLE;
            end else begin
              state <= S_NEW;
            end
          end
        end
        S_NEW: begin
          if (comp == Cw'(NComp - 1)) begin
            total     <= total + 1'b1;
            res_kind  <= 3'b001;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            comp <= comp + 1'b1;
          end
        end
        S_URD: state <= S_DIV;
        S_DIV: state <= S_WB;
        S_WB:  if (sts.div_done) begin
          if (comp == Cw'(NComp - 1)) begin
            res_kind  <= 3'b000;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            comp  <= comp + 1'b1;
            state <= S_GATH;
          end
        end
        S_GATH: state <= S_URD;
        S_GRD: begin
          if (comp == Cw'(NComp - 1)) begin
            res_kind  <= 3'b000;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            comp <= comp + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### rtl/core/radius_leader_clustering.sv
`default_nettype none
// ----------------------------------------------------------------------------
// radius_leader_clustering: leader clustering of detections by join radius
// One request at a time. A request scans each stored cluster in turn (read,
// square, compare, decide), then opens a cluster, reports a cluster whose
// count is saturated, or updates one, where a bit-serial divider recomputes
// each of the seven centroid components. A dropped detection ends with the
// scan. A clear request is answered from the idle state without a scan. The
// result waits in an output register; the next request is taken once it has
// been delivered.
// ----------------------------------------------------------------------------
module radius_leader_clustering import rlc_pkg::*; #(
  parameter int MaxClusters = MaxClustersDef,
  parameter int CoordWidth  = CoordWidthDef,
  parameter int CountWidth  = CountWidthDef
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  // pos_x, pos_y, pos_z, plane_a, plane_b, plane_c, plane_d
  input  wire logic [((7*CoordWidth+7)/8)*8-1:0] s_tdata,
  // action
  input  wire logic                     s_tuser,
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  // cluster_index, created, dropped, member_count, reliable,
  // mean_x, mean_y, mean_z, mean_a, mean_b, mean_c, mean_d
  output logic [((8+CountWidth+7*CoordWidth+7)/8)*8-1:0] m_tdata,
  input  wire logic                     cfg_we,
  input  wire logic                     cfg_index,
  input  wire logic [RadiusWidth-1:0]   cfg_data
);
  logic [RadiusWidth-1:0] radius_squared;
  logic [ThreshWidth-1:0] reliable_threshold;
  rlc_cmd_t cmd;
  rlc_sts_t sts;
  logic [$clog2(MaxClusters)-1:0] scan_idx;
  logic [$clog2(NComp)-1:0] comp;
  logic [2:0] kind;
  logic [CountWidth-1:0] cnt;
  logic [NComp*CoordWidth-1:0] means;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_squared     <= RadiusReset;
      reliable_threshold <= ThreshReset;
    end else if (cfg_we) begin
      if (cfg_index == CfgRadius) radius_squared <= cfg_data;
      else reliable_threshold <= cfg_data[ThreshWidth-1:0];
    end
  end

  rlc_controller #(.MaxClusters(MaxClusters)) u_ctrl (
    .clk, .rst,
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .action   (s_tuser),
    .cmd, .sts, .scan_idx, .comp,
    .res_valid(m_tvalid),
    .res_ready(m_tready),
    .res_kind (kind)
  );

  rlc_datapath #(.MaxClusters(MaxClusters), .CoordWidth(CoordWidth),
                 .CountWidth(CountWidth)) u_dp (
    .clk, .rst, .cmd, .sts, .scan_idx, .comp,
    .radius_squared,
    .det_in   (s_tdata[NComp*CoordWidth-1:0]),
    .count_out(cnt),
    .mean_out (means)
  );

  logic zero_res;
  logic [IndexWidth-1:0] idx5;
  assign zero_res = kind[2];
  assign idx5 = IndexWidth'(scan_idx);

  always_comb begin
    m_tdata = '0;
    if (!zero_res) begin
      m_tdata[4:0] = idx5;
      m_tdata[5]   = kind[0];
      m_tdata[7 +: CountWidth] = cnt;
      m_tdata[7+CountWidth] = (32'(cnt) > 32'(reliable_threshold));
      m_tdata[8+CountWidth +: NComp*CoordWidth] = means;
    end
    m_tdata[6] = kind[1];
  end
endmodule
`default_nettype wire

### rtl/core/rlc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlc_checker: port-level checks for radius_leader_clustering
// Watches the stream ports and flags broken result rules.
// ----------------------------------------------------------------------------
module rlc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [7:0]  m_low
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
  a_one: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> !m_tvalid) else $error("request while result pending");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> m_tvalid && m_low == 8'd0)
    else $error("clear result not zero");
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_low[5] && m_low[6])) else $error("created and dropped");
endmodule

bind radius_leader_clustering rlc_checker u_chk (
  .clk, .rst, .s_tvalid, .s_tready, .s_tuser, .m_tvalid, .m_tready,
  .m_low(m_tdata[7:0])
);
`default_nettype wire

### bench/tb_radius_leader_clustering.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_radius_leader_clustering: self-checking bench for leader clustering
// Drives detections and clear requests through the stream input, predicts each
// cluster update from its own table of sums, counts and centroids, and checks
// every result field by field. Runs through several radius and threshold
// settings, with random gaps and stalls on both sides in all but the last.
// ----------------------------------------------------------------------------
module tb_radius_leader_clustering;
  import rlc_pkg::*;

  localparam int NClust = 32;
  localparam int CW     = 24;
  localparam int InW    = 168;
  localparam int OutW   = 192;
  localparam int StallLimit = 20000;

  typedef struct {
    bit [4:0]  idx;
    bit        created;
    bit        dropped;
    bit [15:0] count;
    bit        reliable;
    bit [CW-1:0] mean [NComp];
  } cluster_res_t;

  typedef struct {
    bit          act;
    bit [CW-1:0] f [NComp];
    bit          typed;
    bit [4:0]    idx;
    bit          created;
    bit [15:0]   count;
  } req_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [InW-1:0] s_tdata = '0;
  logic s_tuser = ActAdd;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OutW-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic cfg_index = CfgRadius;
  logic [RadiusWidth-1:0] cfg_data = '0;

  radius_leader_clustering dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // cluster table copy
  longint          sum_tab  [NClust][NComp];
  longint          mean_tab [NClust][NComp];
  longint unsigned count_tab [NClust];
  int              total_clusters;
  longint unsigned join_radius;
  longint unsigned reliable_min;

  cluster_res_t expected_q [$];
  int errors = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;
  int idle_cycles = 0;

  function automatic longint sx(bit [CW-1:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic cluster_res_t emit_cluster(int i, bit cr);
    cluster_res_t r;
    r = '{default: '0};
    r.idx = i[4:0];
    r.created = cr;
    r.count = count_tab[i][15:0];
    r.reliable = count_tab[i] > reliable_min;
    for (int n = 0; n < NComp; n++) r.mean[n] = mean_tab[i][n][CW-1:0];
    return r;
  endfunction

  function automatic cluster_res_t cluster_step(bit act, bit [InW-1:0] data);
    cluster_res_t r;
    longint det [NComp];
    longint unsigned acc, d;
    r = '{default: '0};
    if (act == ActClear) begin
      total_clusters = 0;
      return r;
    end
    for (int n = 0; n < NComp; n++) det[n] = sx(data[n*CW +: CW]);
    for (int i = 0; i < total_clusters; i++) begin
      acc = 0;
      for (int n = 0; n < 3; n++) begin
        d = (mean_tab[i][n] > det[n]) ? mean_tab[i][n] - det[n] : det[n] - mean_tab[i][n];
        acc += d * d;
      end
      if (acc < join_radius) begin
        if (count_tab[i] < 65535) begin
          count_tab[i]++;
          for (int n = 0; n < NComp; n++) begin
            sum_tab[i][n] += det[n];
            mean_tab[i][n] = sum_tab[i][n] / longint'(count_tab[i]);
          end
        end
        return emit_cluster(i, 1'b0);
      end
    end
    if (total_clusters >= NClust) begin
      r.dropped = 1'b1;
      return r;
    end
    count_tab[total_clusters] = 1;
    for (int n = 0; n < NComp; n++) begin
      sum_tab[total_clusters][n] = det[n];
      mean_tab[total_clusters][n] = det[n];
    end
    total_clusters++;
    return emit_cluster(total_clusters - 1, 1'b1);
  endfunction

  task automatic send_req(bit act, bit [InW-1:0] data, bit typed, cluster_res_t typed_r);
    cluster_res_t r;
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= act;
    s_tdata <= data;
    do @(posedge clk); while (!s_tready);
    r = cluster_step(act, data);
    expected_q.insert(expected_q.size(), typed ? typed_r : r);
  endtask

  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, longint unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[RadiusWidth-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgRadius) join_radius = val[RadiusWidth-1:0];
    else reliable_min = val[15:0];
  endtask

  function automatic bit [CW-1:0] clamp24(longint v);
    if (v > 8388607) return 24'h7FFFFF;
    if (v < -8388608) return 24'h800000;
    return v[CW-1:0];
  endfunction

  function automatic bit [InW-1:0] random_detection();
    bit [InW-1:0] d;
    int pick, k;
    for (int n = 0; n < NComp; n++) d[n*CW +: CW] = CW'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 65 && total_clusters > 0) begin
      k = $urandom_range(0, total_clusters - 1);
      for (int n = 0; n < 3; n++)
        d[n*CW +: CW] = clamp24(mean_tab[k][n] + $signed($urandom_range(0, 40000)) - 20000);
    end else if (pick < 75) begin
      for (int n = 0; n < NComp; n++)
        d[n*CW +: CW] = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
    end
    return d;
  endfunction

  // receiver
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (3000) @(negedge clk);
        hold_req = 1'b0;
      end
      if (no_idle) m_tready <= 1'b1;
      else if (burst > 0) begin
        burst--;
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 9) - 1;
        m_tready <= 1'b0;
      end else m_tready <= 1'b1;
    end
  end

  // result check
  always @(posedge clk) begin
    cluster_res_t e;
    cluster_res_t a;
    if (!rst && m_tvalid && m_tready) begin
      a.idx = m_tdata[4:0];
      a.created = m_tdata[5];
      a.dropped = m_tdata[6];
      a.count = m_tdata[22:7];
      a.reliable = m_tdata[23];
      for (int n = 0; n < NComp; n++) a.mean[n] = m_tdata[24 + n*CW +: CW];
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_tdata);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (a.idx != e.idx) begin
          $display("%0t: cluster_index exp %0d got %0d", $time, e.idx, a.idx); errors++;
        end
        if (a.created != e.created) begin
          $display("%0t: created exp %0d got %0d", $time, e.created, a.created); errors++;
        end
        if (a.dropped != e.dropped) begin
          $display("%0t: dropped exp %0d got %0d", $time, e.dropped, a.dropped); errors++;
        end
        if (a.count != e.count) begin
          $display("%0t: member_count exp %0d got %0d", $time, e.count, a.count); errors++;
        end
        if (a.reliable != e.reliable) begin
          $display("%0t: reliable exp %0d got %0d", $time, e.reliable, a.reliable); errors++;
        end
        for (int n = 0; n < NComp; n++)
          if (a.mean[n] != e.mean[n]) begin
            $display("%0t: mean[%0d] exp %h got %h", $time, n, e.mean[n], a.mean[n]);
            errors++;
          end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic req_row_t mk_row(bit act, bit [CW-1:0] p, bit [CW-1:0] q, bit typed,
                                      int idx, bit cr, int cnt);
    req_row_t w;
    w.act = act;
    for (int n = 0; n < NComp; n++) w.f[n] = n[0] ? q : p;
    w.typed = typed;
    w.idx = idx[4:0];
    w.created = cr;
    w.count = cnt[15:0];
    return w;
  endfunction

  initial begin
    req_row_t rows [$];
    cluster_res_t tr;
    bit [InW-1:0] d;
    longint unsigned rad_set [5];
    int thr_set [5];

    join_radius = RadiusReset;
    reliable_min = ThreshReset;
    total_clusters = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    rows.insert(rows.size(), mk_row(ActClear, 24'h000000, 24'h000000, 1, 0, 0, 0));
    rows.insert(rows.size(), mk_row(ActAdd,   24'h800000, 24'h800000, 1, 0, 1, 1));
    rows.insert(rows.size(), mk_row(ActAdd,   24'h7FFFFF, 24'h7FFFFF, 1, 1, 1, 1));
    rows.insert(rows.size(), mk_row(ActAdd,   24'h000000, 24'h000000, 1, 2, 1, 1));
    rows.insert(rows.size(), mk_row(ActAdd,   24'h000000, 24'h123456, 0, 0, 0, 0));
    rows.insert(rows.size(), mk_row(ActAdd,   24'h003E80, 24'hFFC180, 0, 0, 0, 0));
    rows.insert(rows.size(), mk_row(ActAdd,   24'h008000, 24'h7FFFFF, 0, 0, 0, 0));
    rows.insert(rows.size(), mk_row(ActAdd,   24'h800000, 24'h000001, 0, 0, 0, 0));
    rows.insert(rows.size(), mk_row(ActAdd,   24'h555555, 24'hAAAAAA, 0, 0, 0, 0));
    rows.insert(rows.size(), mk_row(ActAdd,   24'hFFFFFF, 24'h800000, 0, 0, 0, 0));
    rows.insert(rows.size(), mk_row(ActClear, 24'h7FFFFF, 24'h555555, 1, 0, 0, 0));
    rows.insert(rows.size(), mk_row(ActAdd,   24'hAAAAAA, 24'h555555, 1, 0, 1, 1));
    rows.insert(rows.size(), mk_row(ActAdd,   24'hAAAAAA, 24'h000000, 0, 0, 0, 0));

    foreach (rows[r]) begin
      for (int n = 0; n < NComp; n++) d[n*CW +: CW] = rows[r].f[n];
      tr = '{default: '0};
      tr.idx = rows[r].idx;
      tr.created = rows[r].created;
      tr.count = rows[r].count;
      if (rows[r].act == ActAdd)
        for (int n = 0; n < NComp; n++) tr.mean[n] = rows[r].f[n];
      send_req(rows[r].act, d, rows[r].typed, tr);
    end
    drain_results();

    rad_set = '{48'd1073741824, 48'd0, 48'hFFFFFFFFFFFF, 48'd17179869184, 48'd0};
    thr_set = '{10, 0, 65535, 3, 0};
    rad_set[4] = {$urandom_range(0, 255), $urandom()} & 48'h3FFFFFFFF;
    thr_set[4] = $urandom_range(0, 40);
    tr = '{default: '0};

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CfgRadius, rad_set[ph]);
      write_reg(CfgThresh, thr_set[ph]);
      if (ph == 4) no_idle = 1'b1;
      for (int it = 0; it < 100; it++) begin
        if (ph == 0 && it == 20) hold_req = 1'b1;
        if (ph == 0 && it == 50) drain_results();
        if ($urandom_range(0, 39) == 0)
          send_req(ActClear, InW'({$urandom(), $urandom()}), 0, tr);
        else send_req(ActAdd, random_detection(), 0, tr);
      end
      drain_results();
    end

    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire
